[hw/rtl/kpm_pkg.sv]
// ----------------------------------------------------------------------------
// kpm_pkg
// types and codes shared by the keyed page map modules
// ----------------------------------------------------------------------------
`default_nettype none

package kpm_pkg;

    localparam int unsigned OFS_W   = 48;
    localparam int unsigned FILE_W  = 32;
    localparam int unsigned REFS_W  = 16;
    localparam int unsigned TOTAL_W = 7;
    localparam int unsigned CNT_W   = 32;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_DIRTY  = 3'd2,
        OP_REF    = 3'd3,
        OP_PUT    = 3'd4,
        OP_INVAL  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADARG = 2'd1,
        ST_EXISTS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [FILE_W-1:0] file_id;
        logic [OFS_W-1:0]  byte_offset;
        logic [OFS_W-1:0]  frame_addr;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [OFS_W-1:0]   frame_out;
        logic [OFS_W-1:0]   removed_offset;
        logic               release_frame;
        logic               last;
        logic [TOTAL_W-1:0] entry_total;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
    } out_t;

endpackage

`default_nettype wire

[hw/rtl/kpm_ram.sv]
// ----------------------------------------------------------------------------
// kpm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/keyed_page_map_with_refcounts_top.sv]
// ----------------------------------------------------------------------------
// keyed_page_map_with_refcounts_top
// page map from (file, page) to frame with dirty mark and reference count
// ----------------------------------------------------------------------------
// One item at a time. Each valid item walks every slot of the entry memory, a
// read and then a compare per slot, so lookup, insert, dirty, ref and put walk
// once; invalidate walks twice (count, then remove), sends one result beat
// per removed entry and ends the second walk at the last removed entry, or
// walks once when no entry of the file is present. The walk through the
// single-read-port entry memory sets the rate. A request with file 0 or an
// unknown operation answers without a walk. No clearing pass.
`default_nettype none

module keyed_page_map_with_refcounts_top #(
    parameter int unsigned ENTRIES    = 64,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire kpm_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output kpm_pkg::out_t       m_data
);

    import kpm_pkg::*;

    localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned PW   = OFS_W - PAGE_SHIFT;
    localparam int unsigned EW   = FILE_W + PW + OFS_W + 1 + REFS_W;

    state_t              state_reg, state_next;
    in_t                 req_reg;
    logic [IDXW-1:0]     idx_reg;
    logic                found_reg;
    logic [IDXW-1:0]     slot_reg;
    logic [EW-1:0]       ent_reg;
    logic                free_found_reg;
    logic [IDXW-1:0]     free_reg;
    logic [TOTAL_W-1:0]  cnt_reg;
    logic [TOTAL_W-1:0]  ecnt_reg;
    logic                pass_reg;
    logic                done_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [CNT_W-1:0]    hit_reg;
    logic [CNT_W-1:0]    miss_reg;
    logic [TOTAL_W-1:0]  live_reg;
    out_t                res_reg;
    out_t                out_reg;
    logic                m_valid_reg;

    logic [EW-1:0]       rd_data;
    logic                wr_en;
    logic [IDXW-1:0]     wr_addr;
    logic [EW-1:0]       wr_data;

    logic [FILE_W-1:0]   rd_file;
    logic [PW-1:0]       rd_page;
    logic [OFS_W-1:0]    rd_frame;
    logic [REFS_W-1:0]   rd_refs;
    logic [OFS_W-1:0]    ent_frame;
    logic [REFS_W-1:0]   ent_refs;
    logic [PW-1:0]       req_page;
    logic                is_inval;
    logic                file_hit;
    logic                key_hit;
    logic                last_idx;
    logic [TOTAL_W-1:0]  cnt_next;
    logic                bad_req;
    logic                out_free;

    out_t                fin_res;
    out_t                none_res;
    out_t                bad_res;
    out_t                rem_res;
    logic [CNT_W-1:0]    hit_next;
    logic [CNT_W-1:0]    miss_next;
    logic [TOTAL_W-1:0]  live_next;
    logic                set_valid;

    kpm_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IDXW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign rd_file   = rd_data[EW-1 -: FILE_W];
    assign rd_page   = rd_data[EW-FILE_W-1 -: PW];
    assign rd_frame  = rd_data[REFS_W+1 +: OFS_W];
    assign rd_refs   = rd_data[REFS_W-1:0];
    assign ent_frame = ent_reg[REFS_W+1 +: OFS_W];
    assign ent_refs  = ent_reg[REFS_W-1:0];
    assign req_page  = req_reg.byte_offset[OFS_W-1:PAGE_SHIFT];
    assign is_inval  = (req_reg.operation == OP_INVAL);
    assign file_hit  = valid_reg[idx_reg] && (rd_file == req_reg.file_id);
    assign key_hit   = file_hit && (rd_page == req_page);
    assign last_idx  = (idx_reg == IDXW'(ENTRIES - 1));
    assign cnt_next  = cnt_reg + TOTAL_W'(file_hit);
    assign bad_req   = (s_data.file_id == '0) || (s_data.operation > OP_INVAL);
    assign out_free  = !m_valid_reg || m_ready;

    // preset and removal result beats
    always_comb begin
        none_res             = '0;
        none_res.last        = 1'b1;
        none_res.entry_total = live_reg;
        none_res.hit_total   = hit_reg;
        none_res.miss_total  = miss_reg;
        bad_res              = none_res;
        bad_res.status       = ST_BADARG;
        rem_res                = '0;
        rem_res.found          = 1'b1;
        rem_res.frame_out      = rd_frame;
        rem_res.removed_offset = {rd_page, PAGE_SHIFT'(0)};
        rem_res.release_frame  = (rd_refs <= REFS_W'(1));
        rem_res.last           = (ecnt_reg + 1'b1 == cnt_reg);
        rem_res.entry_total    = live_reg;
        rem_res.hit_total      = hit_reg;
        rem_res.miss_total     = miss_reg;
    end

    // finishing step for single-result operations
    always_comb begin
        fin_res               = '0;
        fin_res.last          = 1'b1;
        hit_next              = hit_reg;
        miss_next             = miss_reg;
        live_next             = live_reg;
        set_valid             = 1'b0;
        wr_en                 = 1'b0;
        wr_addr               = slot_reg;
        wr_data               = ent_reg;
        case (req_reg.operation)
            OP_LOOKUP: begin
                if (found_reg) begin
                    hit_next          = hit_reg + 1'b1;
                    fin_res.found     = 1'b1;
                    fin_res.frame_out = ent_frame;
                end else begin
                    miss_next = miss_reg + 1'b1;
                end
            end
            OP_INSERT: begin
                if (req_reg.frame_addr == '0) begin
                    fin_res.status = ST_BADARG;
                end else if (found_reg) begin
                    fin_res.status    = ST_EXISTS;
                    fin_res.found     = 1'b1;
                    fin_res.frame_out = ent_frame;
                end else if (!free_found_reg) begin
                    fin_res.status = ST_FULL;
                end else begin
                    set_valid = (state_reg == S_FIN);
                    wr_en     = (state_reg == S_FIN);
                    wr_addr   = free_reg;
                    wr_data   = {req_reg.file_id, req_page, req_reg.frame_addr, 1'b0,
                                 REFS_W'(1)};
                    live_next = live_reg + 1'b1;
                end
            end
            OP_DIRTY, OP_REF, OP_PUT: begin
                if (found_reg) begin
                    fin_res.found     = 1'b1;
                    fin_res.frame_out = ent_frame;
                    wr_en             = (state_reg == S_FIN);
                    if (req_reg.operation == OP_DIRTY) begin
                        wr_data[REFS_W] = 1'b1;
                    end else if (req_reg.operation == OP_REF) begin
                        wr_data[REFS_W-1:0] = (&ent_refs) ? ent_refs : ent_refs + 1'b1;
                    end else begin
                        wr_data[REFS_W-1:0] = (ent_refs == '0) ? ent_refs
                                                               : ent_refs - 1'b1;
                    end
                end
            end
            default: begin
                fin_res.status = ST_BADARG;
            end
        endcase
        fin_res.entry_total = live_next;
        fin_res.hit_total   = hit_next;
        fin_res.miss_total  = miss_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = bad_req ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (is_inval && pass_reg && file_hit) begin
                    state_next = S_OUT;
                end else if (last_idx) begin
                    if (!is_inval) begin
                        state_next = S_FIN;
                    end else if (!pass_reg) begin
                        state_next = (cnt_next == '0) ? S_OUT : S_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_RD;
                end
            end
            S_FIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = done_reg ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == S_IDLE);
        m_valid = m_valid_reg;
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            hit_reg     <= '0;
            miss_reg    <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_FIN) begin
                hit_reg  <= hit_next;
                miss_reg <= miss_next;
                live_reg <= live_next;
                if (set_valid) begin
                    valid_reg[free_reg] <= 1'b1;
                end
            end
            if (state_reg == S_CHK && is_inval) begin
                if (!pass_reg && last_idx) begin
                    live_reg <= live_reg - cnt_next;
                end
                if (pass_reg && file_hit) begin
                    valid_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            out_reg <= res_reg;
        end
        case (state_reg)
            S_IDLE: begin
                req_reg        <= s_data;
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                cnt_reg        <= '0;
                ecnt_reg       <= '0;
                pass_reg       <= 1'b0;
                done_reg       <= 1'b1;
                res_reg        <= bad_res;
            end
            S_CHK: begin
                if (!last_idx) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (!is_inval) begin
                    if (key_hit && !found_reg) begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_reg;
                        ent_reg   <= rd_data;
                    end
                    if (!valid_reg[idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_reg       <= idx_reg;
                    end
                end else if (!pass_reg) begin
                    cnt_reg <= cnt_next;
                    if (last_idx) begin
                        idx_reg  <= '0;
                        pass_reg <= 1'b1;
                        done_reg <= 1'b1;
                        res_reg  <= none_res;
                    end
                end else if (file_hit) begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    done_reg <= rem_res.last;
                    res_reg  <= rem_res;
                end
            end
            S_FIN: begin
                res_reg  <= fin_res;
                done_reg <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> live_reg == TOTAL_W'($countones(valid_reg)))
        else $error("live count differs from valid slots");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == S_FIN)
        else $error("entry write outside finish step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= TOTAL_W'(ENTRIES))
        else $error("live count above capacity");

endmodule

`default_nettype wire

[tb/sv/tb_keyed_page_map_with_refcounts_top.sv]
// ----------------------------------------------------------------------------
// tb_keyed_page_map_with_refcounts_top
// self-checking bench for the keyed page map with reference counts
// ----------------------------------------------------------------------------
// A queue of requests feeds a valid/ready driver. Each accepted beat is run
// through a behavioral page map kept in the bench, and the result beats it
// predicts are queued. A monitor compares every result beat, field by field,
// against the oldest prediction. Random stimulus mostly works a small pool of
// files and pages for hits, duplicates and multi-entry invalidates; directed
// items fill the store. Sender and receiver idling go through several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_page_map_with_refcounts_top;
    import kpm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 64;
    localparam int PAGE_SHIFT = 12;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    keyed_page_map_with_refcounts_top #(
        .ENTRIES(ENTRIES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // page map mirror
    logic        map_valid [ENTRIES];
    logic [31:0] map_file  [ENTRIES];
    logic [35:0] map_page  [ENTRIES];
    logic [47:0] map_frame [ENTRIES];
    logic        map_dirty [ENTRIES];
    logic [15:0] map_refs  [ENTRIES];
    logic [31:0] hits;
    logic [31:0] misses;
    logic [6:0]  live;

    in_t  request_q [$];
    out_t result_q  [$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic out_t make_result(logic [1:0] st, logic fnd, logic [47:0] frm,
                                         logic [47:0] ofs, logic rel, logic lst);
        out_t r;
        r.status         = st;
        r.found          = fnd;
        r.frame_out      = frm;
        r.removed_offset = ofs;
        r.release_frame  = rel;
        r.last           = lst;
        r.entry_total    = '0;
        r.hit_total      = '0;
        r.miss_total     = '0;
        return r;
    endfunction

    task automatic predict_map_access(input in_t req);
        out_t        beats [$];
        int          hit_slot;
        int          free_slot;
        logic [35:0] page;
        begin
            page      = 36'(req.byte_offset >> PAGE_SHIFT);
            hit_slot  = -1;
            free_slot = -1;
            if (req.file_id == '0 || req.operation > OP_INVAL) begin
                beats.push_back(make_result(ST_BADARG, 1'b0, '0, '0, 1'b0, 1'b1));
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_slot < 0 && map_valid[i] && map_file[i] == req.file_id
                            && map_page[i] == page)
                        hit_slot = i;
                    if (free_slot < 0 && !map_valid[i])
                        free_slot = i;
                end
                case (op_t'(req.operation))
                    OP_LOOKUP: begin
                        if (hit_slot >= 0) begin
                            hits++;
                            beats.push_back(make_result(ST_OK, 1'b1, map_frame[hit_slot],
                                                        '0, 1'b0, 1'b1));
                        end else begin
                            misses++;
                            beats.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1));
                        end
                    end
                    OP_INSERT: begin
                        if (req.frame_addr == '0) begin
                            beats.push_back(make_result(ST_BADARG, 1'b0, '0, '0, 1'b0,
                                                        1'b1));
                        end else if (hit_slot >= 0) begin
                            beats.push_back(make_result(ST_EXISTS, 1'b1,
                                                        map_frame[hit_slot], '0, 1'b0,
                                                        1'b1));
                        end else if (free_slot < 0) begin
                            beats.push_back(make_result(ST_FULL, 1'b0, '0, '0, 1'b0, 1'b1));
                        end else begin
                            map_valid[free_slot] = 1'b1;
                            map_file[free_slot]  = req.file_id;
                            map_page[free_slot]  = page;
                            map_frame[free_slot] = req.frame_addr;
                            map_dirty[free_slot] = 1'b0;
                            map_refs[free_slot]  = 16'd1;
                            live++;
                            beats.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1));
                        end
                    end
                    OP_DIRTY, OP_REF, OP_PUT: begin
                        if (hit_slot >= 0) begin
                            if (req.operation == OP_DIRTY)
                                map_dirty[hit_slot] = 1'b1;
                            else if (req.operation == OP_REF) begin
                                if (map_refs[hit_slot] != 16'hFFFF)
                                    map_refs[hit_slot]++;
                            end else if (map_refs[hit_slot] != 16'd0)
                                map_refs[hit_slot]--;
                            beats.push_back(make_result(ST_OK, 1'b1, map_frame[hit_slot],
                                                        '0, 1'b0, 1'b1));
                        end else begin
                            beats.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1));
                        end
                    end
                    default: begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (map_valid[i] && map_file[i] == req.file_id) begin
                                map_valid[i] = 1'b0;
                                if (live != 0)
                                    live--;
                                beats.push_back(make_result(ST_OK, 1'b1, map_frame[i],
                                    48'(map_page[i]) << PAGE_SHIFT,
                                    map_refs[i] <= 16'd1, 1'b0));
                            end
                        end
                        if (beats.size() == 0)
                            beats.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1));
                        else
                            beats[beats.size()-1].last = 1'b1;
                    end
                endcase
            end
            foreach (beats[k]) begin
                beats[k].entry_total = live;
                beats[k].hit_total   = hits;
                beats[k].miss_total  = misses;
                result_q.push_back(beats[k]);
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_map_access(s_data);
            end
            if ((!s_valid || s_ready) && request_q.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= request_q.pop_front();
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_t exp_beat;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    exp_beat = result_q.pop_front();
                    if (m_data.status !== exp_beat.status) begin
                        $error("status expected %0d actual %0d", exp_beat.status,
                               m_data.status);
                        fail_count++;
                    end
                    if (m_data.found !== exp_beat.found) begin
                        $error("found expected %0d actual %0d", exp_beat.found,
                               m_data.found);
                        fail_count++;
                    end
                    if (m_data.frame_out !== exp_beat.frame_out) begin
                        $error("frame_out expected %h actual %h", exp_beat.frame_out,
                               m_data.frame_out);
                        fail_count++;
                    end
                    if (m_data.removed_offset !== exp_beat.removed_offset) begin
                        $error("removed_offset expected %h actual %h",
                               exp_beat.removed_offset, m_data.removed_offset);
                        fail_count++;
                    end
                    if (m_data.release_frame !== exp_beat.release_frame) begin
                        $error("release_frame expected %0d actual %0d",
                               exp_beat.release_frame, m_data.release_frame);
                        fail_count++;
                    end
                    if (m_data.last !== exp_beat.last) begin
                        $error("last expected %0d actual %0d", exp_beat.last,
                               m_data.last);
                        fail_count++;
                    end
                    if (m_data.entry_total !== exp_beat.entry_total) begin
                        $error("entry_total expected %0d actual %0d",
                               exp_beat.entry_total, m_data.entry_total);
                        fail_count++;
                    end
                    if (m_data.hit_total !== exp_beat.hit_total) begin
                        $error("hit_total expected %0d actual %0d", exp_beat.hit_total,
                               m_data.hit_total);
                        fail_count++;
                    end
                    if (m_data.miss_total !== exp_beat.miss_total) begin
                        $error("miss_total expected %0d actual %0d",
                               exp_beat.miss_total, m_data.miss_total);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_t make_request(logic [2:0] op, logic [31:0] file,
                                         logic [47:0] ofs, logic [47:0] frm);
        in_t r;
        r.operation   = op;
        r.file_id     = file;
        r.byte_offset = ofs;
        r.frame_addr  = frm;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()} >> 16);
    endfunction

    function automatic in_t random_request();
        logic [31:0] file;
        logic [47:0] ofs;
        logic [2:0]  op;
        int          pick;
        pick = $urandom_range(99);
        // small key pool so that entries get hit; wide values for bit coverage
        file = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(1, 4));
        if ($urandom_range(19) == 0)
            file = '0;
        ofs = ($urandom_range(4) == 0) ? rand48()
            : (48'($urandom_range(0, 7)) << PAGE_SHIFT) | 48'($urandom_range(0, 4095));
        if (pick < 30)      op = OP_INSERT;
        else if (pick < 50) op = OP_LOOKUP;
        else if (pick < 60) op = OP_DIRTY;
        else if (pick < 72) op = OP_REF;
        else if (pick < 84) op = OP_PUT;
        else if (pick < 94) op = OP_INVAL;
        else                op = 3'($urandom_range(6, 7));
        return make_request(op, file, ofs,
                            ($urandom_range(29) == 0) ? 48'd0 : rand48() | 48'd1);
    endfunction

    initial begin
        int phase_items;
        fail_count     = 0;
        hits           = '0;
        misses         = '0;
        live           = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            map_valid[i] = 1'b0;
            map_file[i]  = '0;
            map_page[i]  = '0;
            map_frame[i] = '0;
            map_dirty[i] = 1'b0;
            map_refs[i]  = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        request_q.push_back(make_request(OP_LOOKUP, 32'd1, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                         48'hFFFF_FFFF_FFFF));
        request_q.push_back(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_F000,
                                         48'd0));
        request_q.push_back(make_request(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_F123,
                                         48'd5));
        request_q.push_back(make_request(OP_INSERT, 32'd0, 48'd0, 48'd7));
        request_q.push_back(make_request(OP_INSERT, 32'd1, 48'h1000, 48'd0));
        request_q.push_back(make_request(OP_INSERT, 32'd1, 48'h1000, 48'h1234_5678_9ABC));
        request_q.push_back(make_request(OP_DIRTY, 32'd1, 48'h1FFF, 48'd0));
        request_q.push_back(make_request(OP_DIRTY, 32'd1, 48'h2000, 48'd0));
        request_q.push_back(make_request(OP_PUT, 32'd1, 48'h1000, 48'd0));
        request_q.push_back(make_request(OP_PUT, 32'd1, 48'h1000, 48'd0));
        request_q.push_back(make_request(OP_REF, 32'd1, 48'h1000, 48'd0));
        request_q.push_back(make_request(OP_REF, 32'd2, 48'h1000, 48'd0));
        request_q.push_back(make_request(3'd6, 32'd1, 48'h1000, 48'd1));
        request_q.push_back(make_request(3'd7, 32'd1, 48'h1000, 48'd1));
        request_q.push_back(make_request(OP_INVAL, 32'd0, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INVAL, 32'd9, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INVAL, 32'd1, 48'd0, 48'd0));
        // fill the store, hit full, then drop every entry of each file in turn
        for (int i = 0; i < ENTRIES; i++)
            request_q.push_back(make_request(OP_INSERT, 32'(3 + i % 2), 48'(i) << 12,
                                             48'(i + 1)));
        request_q.push_back(make_request(OP_INSERT, 32'd5, 48'd0, 48'd1));
        request_q.push_back(make_request(OP_INVAL, 32'd3, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INVAL, 32'd4, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INVAL, 32'hFFFF_FFFF, 48'd0, 48'd0));
        // a few refs on one entry, then drop it with refs above one
        request_q.push_back(make_request(OP_INSERT, 32'd6, 48'd0, 48'd9));
        for (int i = 0; i < 3; i++)
            request_q.push_back(make_request(OP_REF, 32'd6, 48'd0, 48'd0));
        request_q.push_back(make_request(OP_INVAL, 32'd6, 48'd0, 48'd0));

        // random part in idling phases
        for (int ph = 0; ph < 4; ph++) begin
            wait (request_q.size() == 0);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            phase_items = 40;
            for (int i = 0; i < phase_items; i++)
                request_q.push_back(random_request());
        end
        wait (request_q.size() == 0);
        @(posedge aclk);
        wait (!s_valid && result_q.size() == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/kpm_pkg.sv
hw/rtl/kpm_ram.sv
hw/rtl/keyed_page_map_with_refcounts_top.sv
tb/sv/tb_keyed_page_map_with_refcounts_top.sv
